// ----- src/color_quantize_histogram_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quantized color histogram
// Implication checks on a clock with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef COLOR_QUANTIZE_HISTOGRAM_ASSERT_SVH
`define COLOR_QUANTIZE_HISTOGRAM_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CQH_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define CQH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define CQH_ASSERT_NOW(label, clk, rst_n, pre, post, msg)
`define CQH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- src/cqh_pkg.sv -----
// ----------------------------------------------------------------------------
// cqh_pkg
// Types and constants shared by the quantized color histogram modules.
// ----------------------------------------------------------------------------
package cqh_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W  = 8;
	localparam int CODE_W    = 15;
	localparam int CNT_OUT_W = 32;
	localparam int QBITS_W   = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 8;

	// Request commands.
	typedef enum logic {
		CMD_ADD  = 1'b0,
		CMD_READ = 1'b1
	} cqh_cmd_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUANT_BITS = 1'b0,
		REG_GRAY_MODE  = 1'b1
	} cqh_reg_t;

	// Input request.
	typedef struct packed {
		cqh_cmd_t            cmd;
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
		logic [CODE_W-1:0]   bin_select;
		logic                last_pixel;
	} cqh_pixel_t;

	// Result request.
	typedef struct packed {
		logic [CODE_W-1:0]    color_code;
		logic [CNT_OUT_W-1:0] bin_count;
		logic                 image_done;
	} cqh_result_t;

	// Classified job handed from the front to the back.
	typedef struct packed {
		logic              is_read;
		logic [CODE_W-1:0] index;
		logic              last;
	} cqh_job_t;

endpackage

// ----- src/cqh_fifo.sv -----
// ----------------------------------------------------------------------------
// cqh_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module cqh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- src/cqh_front.sv -----
// ----------------------------------------------------------------------------
// cqh_front
// Holds the configuration and turns each request into a bin job.
// ----------------------------------------------------------------------------
module cqh_front #(
	parameter int MAX_QUANT_BITS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  cqh_pkg::cqh_reg_t              cfg_index,
	input  logic [cqh_pkg::CFG_DAT_W-1:0]  cfg_data,
	input  cqh_pkg::cqh_pixel_t            pixel,
	output cqh_pkg::cqh_job_t              job
);

	localparam int ADDR_W = 3 * MAX_QUANT_BITS;
	localparam logic [cqh_pkg::CODE_W-1:0] IDX_MASK =
		cqh_pkg::CODE_W'((32'd1 << ADDR_W) - 32'd1);

	logic [cqh_pkg::QBITS_W-1:0]  quant_bits_q;
	logic                         gray_mode_q;
	logic [cqh_pkg::QBITS_W-1:0]  n_eff;
	logic [3:0]                   drop;
	logic [3:0]                   shift2;
	logic [cqh_pkg::SAMPLE_W-1:0] g_src;
	logic [cqh_pkg::SAMPLE_W-1:0] b_src;
	logic [cqh_pkg::SAMPLE_W-1:0] rq;
	logic [cqh_pkg::SAMPLE_W-1:0] gq;
	logic [cqh_pkg::SAMPLE_W-1:0] bq;
	logic [cqh_pkg::CODE_W-1:0]   code;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_bits_q <= cqh_pkg::QBITS_W'(2);
			gray_mode_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cqh_pkg::REG_QUANT_BITS: begin
					quant_bits_q <= cfg_data[cqh_pkg::QBITS_W-1:0];
				end
				cqh_pkg::REG_GRAY_MODE: begin
					gray_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the kept bit count into its legal range.
	always_comb begin
		if (quant_bits_q == '0) begin
			n_eff = cqh_pkg::QBITS_W'(1);
		end else if (quant_bits_q > cqh_pkg::QBITS_W'(MAX_QUANT_BITS)) begin
			n_eff = cqh_pkg::QBITS_W'(MAX_QUANT_BITS);
		end else begin
			n_eff = quant_bits_q;
		end
	end

	// Quantize each channel and pack red, green, blue from high to low.
	always_comb begin
		drop   = 4'd8 - {1'b0, n_eff};
		shift2 = {n_eff, 1'b0};
		g_src  = gray_mode_q ? pixel.red : pixel.green;
		b_src  = gray_mode_q ? pixel.red : pixel.blue;
		rq     = pixel.red >> drop;
		gq     = g_src >> drop;
		bq     = b_src >> drop;
		code   = (cqh_pkg::CODE_W'(rq) << shift2) | (cqh_pkg::CODE_W'(gq) << n_eff)
			| cqh_pkg::CODE_W'(bq);
	end

	// Classify the request into a job for the back end.
	always_comb begin
		if (pixel.cmd == cqh_pkg::CMD_READ) begin
			job.is_read = 1'b1;
			job.index   = pixel.bin_select & IDX_MASK;
			job.last    = 1'b0;
		end else begin
			job.is_read = 1'b0;
			job.index   = code & IDX_MASK;
			job.last    = pixel.last_pixel;
		end
	end

endmodule

// ----- src/cqh_back.sv -----
// ----------------------------------------------------------------------------
// cqh_back
// Read-modify-write of the bin store, with forwarding and a reset clear pass.
// ----------------------------------------------------------------------------
module cqh_back #(
	parameter int ADDR_W      = 15,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  cqh_pkg::cqh_job_t    job,
	output logic                 job_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output cqh_pkg::cqh_result_t res,
	output logic                 clearing
);

	localparam int DEPTH = 1 << ADDR_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNT_WIDTH-1:0] mem [DEPTH];
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic                   clr_q;
	logic [ADDR_W-1:0]      clr_addr_q;

	logic                   v_s1;
	cqh_pkg::cqh_job_t      job_s1;
	logic                   fwd_s1;
	logic [COUNT_WIDTH-1:0] fwd_val_s1;

	logic                   adv_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [ADDR_W-1:0]      head_addr;
	logic [COUNT_WIDTH-1:0] cur;
	logic [COUNT_WIDTH-1:0] new_val;
	logic                   wr_en;
	logic [ADDR_W-1:0]      wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;

	assign clearing  = clr_q;
	assign addr_s1   = job_s1.index[ADDR_W-1:0];
	assign head_addr = job.index[ADDR_W-1:0];
	assign adv_s1    = v_s1 && !res_full;
	assign job_pop   = job_valid && !clr_q && (!v_s1 || adv_s1);

	// Current bin value, taking the write of the previous job if it hit the same bin.
	always_comb begin
		cur = fwd_s1 ? fwd_val_s1 : rdata_q;
		if (job_s1.is_read) begin
			new_val = '0;
		end else if (cur == CNT_MAX) begin
			new_val = cur;
		end else begin
			new_val = cur + 1'b1;
		end
	end

	// Write port: the clear pass owns it after reset, then the job stage.
	always_comb begin
		if (clr_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = '0;
		end else begin
			wr_en   = adv_s1;
			wr_addr = addr_s1;
			wr_data = new_val;
		end
	end

	// Bin store.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (job_pop) begin
			rdata_q <= mem[head_addr];
		end
	end

	// Clear pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Job stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (job_pop) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// Job stage payload and forwarding of the bin written in the same cycle.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_s1     <= job;
			fwd_s1     <= adv_s1 && (addr_s1 == head_addr);
			fwd_val_s1 <= new_val;
		end
	end

	// Result of the job stage.
	always_comb begin
		res_push       = adv_s1;
		res.color_code = job_s1.index;
		res.bin_count  = cqh_pkg::CNT_OUT_W'(job_s1.is_read ? cur : new_val);
		res.image_done = job_s1.is_read ? 1'b0 : job_s1.last;
	end

endmodule

// ----- src/color_quantize_histogram.sv -----
// Path: an accepted request passes the job queue, the job stage and the result queue.
// Throughput: one request per cycle unless the result queue is full or the clear
// pass runs, sustained by forwarding between neighboring jobs in the bin store update.
// Reset: configuration returns to two bits per channel, color mode; the bin
// store is then cleared one entry a cycle, all 2**(3*MAX_QUANT_BITS) entries (32768
// by default), with full held high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// color_quantize_histogram
// Quantized RGB color histogram with read-and-clear of single bins.
// ----------------------------------------------------------------------------
`include "color_quantize_histogram_assert.svh"

module color_quantize_histogram #(
	parameter int MAX_QUANT_BITS = 5,
	parameter int COUNT_WIDTH    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  cqh_pkg::cqh_reg_t             cfg_index,
	input  logic [cqh_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          push,
	output logic                          full,
	input  cqh_pkg::cqh_pixel_t           pixel,
	output logic                          empty,
	input  logic                          pop,
	output cqh_pkg::cqh_result_t          result
);

	localparam int ADDR_W = 3 * MAX_QUANT_BITS;
	localparam int JOB_W  = $bits(cqh_pkg::cqh_job_t);
	localparam int RES_W  = $bits(cqh_pkg::cqh_result_t);

	cqh_pkg::cqh_job_t    front_job;
	cqh_pkg::cqh_job_t    head_job;
	cqh_pkg::cqh_result_t back_res;
	logic                 job_full;
	logic                 job_empty;
	logic                 job_pop;
	logic                 res_full;
	logic                 res_push;
	logic                 clearing;
	logic                 accept;

	assign full   = job_full || clearing;
	assign accept = push && !full;

	// Front end: configuration and classification.
	cqh_front #(
		.MAX_QUANT_BITS(MAX_QUANT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixel    (pixel),
		.job      (front_job)
	);

	// Job queue between the front and the back.
	cqh_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(2)
	) u_job_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.full  (job_full),
		.wdata (front_job),
		.pop   (job_pop),
		.empty (job_empty),
		.rdata (head_job)
	);

	// Back end: bin update.
	cqh_back #(
		.ADDR_W     (ADDR_W),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!job_empty),
		.job      (head_job),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (back_res),
		.clearing (clearing)
	);

	// Result queue toward the consumer.
	cqh_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.wdata (back_res),
		.pop   (pop),
		.empty (empty),
		.rdata (result)
	);

	// The clear pass keeps requests out and jobs idle.
	`CQH_ASSERT_NOW(a_clear_blocks_input, clk, arst_n, clearing, full && !job_pop, "request taken during clear pass")
	// The back end never pushes into a full result queue.
	`CQH_ASSERT_NOW(a_no_result_overflow, clk, arst_n, res_push, !res_full, "result pushed into full queue")
	// No job or result exists when the clear pass ends.
	`CQH_ASSERT_NOW(a_clean_after_clear, clk, arst_n, $fell(clearing), empty && job_empty, "work present at end of clear pass")
	// An accepted request leaves the job queue non-empty.
	`CQH_ASSERT_NEXT(a_accept_queues_job, clk, arst_n, accept, !job_empty, "accepted request not queued")

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the quantized color histogram. A scoreboard
// keeps its own copy of the bin store and the two registers and predicts the
// code and count of every request. Directed requests cover the sample
// extremes, both commands, quant bit clamping, gray mode and read-and-clear.
// Random phases then run with their own register settings and idling on
// both sides, and one phase holds the receiver off long enough to fill the
// block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH   = 1 << cqh_pkg::CODE_W;
	localparam int STALL_LIMIT   = 100000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_COUNT   = 8;

	// Predicts histogram results and checks them in order.
	class histogram_scoreboard;
		bit [cqh_pkg::CNT_OUT_W-1:0]   counts [STORE_DEPTH];
		bit [cqh_pkg::QBITS_W-1:0]     quant_bits = 3'd2;
		bit                            gray_mode  = 1'b0;
		cqh_pkg::cqh_result_t          expected_results [$];
		logic [cqh_pkg::CODE_W-1:0]    recent_codes [$];
		int                            errors = 0;

		function void set_reg(cqh_pkg::cqh_reg_t idx, logic [cqh_pkg::CFG_DAT_W-1:0] data);
			if (idx == cqh_pkg::REG_QUANT_BITS)
				quant_bits = data[cqh_pkg::QBITS_W-1:0];
			else
				gray_mode = data[0];
		endfunction

		// Applies one accepted request to the bin store and queues its result.
		function void note_request(cqh_pkg::cqh_pixel_t px);
			cqh_pkg::cqh_result_t        res;
			int unsigned                 n;
			int unsigned                 rq, gq, bq, packed_code;
			logic [7:0]                  g, b;
			logic [cqh_pkg::CODE_W-1:0]  code;
			bit [cqh_pkg::CNT_OUT_W-1:0] cnt;
			if (px.cmd == cqh_pkg::CMD_READ) begin
				code = px.bin_select;
				res.color_code = code;
				res.bin_count = counts[code];
				res.image_done = 1'b0;
				counts[code] = '0;
			end else begin
				n = 32'(quant_bits);
				if (n < 1) n = 1;
				if (n > 5) n = 5;
				g = px.green;
				b = px.blue;
				if (gray_mode) begin
					g = px.red;
					b = px.red;
				end
				rq = 32'(px.red) >> (8 - n);
				gq = 32'(g) >> (8 - n);
				bq = 32'(b) >> (8 - n);
				packed_code = (rq << (2 * n)) | (gq << n) | bq;
				code = packed_code[cqh_pkg::CODE_W-1:0];
				cnt = counts[code];
				if (cnt != '1) cnt = cnt + 1'b1;
				counts[code] = cnt;
				res.color_code = code;
				res.bin_count = cnt;
				res.image_done = px.last_pixel;
				recent_codes.push_back(code);
				if (recent_codes.size() > 16) void'(recent_codes.pop_front());
			end
			expected_results.push_back(res);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		// Compares one accepted result with the oldest prediction.
		task check_result(cqh_pkg::cqh_result_t got);
			cqh_pkg::cqh_result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result code %0d count %0d",
					got.color_code, got.bin_count));
				return;
			end
			want = expected_results.pop_front();
			if (got.color_code !== want.color_code)
				report($sformatf("color_code %0d, expected %0d",
					got.color_code, want.color_code));
			if (got.bin_count !== want.bin_count)
				report($sformatf("bin_count %0d, expected %0d (code %0d)",
					got.bin_count, want.bin_count, want.color_code));
			if (got.image_done !== want.image_done)
				report($sformatf("image_done %b, expected %b (code %0d)",
					got.image_done, want.image_done, want.color_code));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	cqh_pkg::cqh_reg_t             cfg_index;
	logic [cqh_pkg::CFG_DAT_W-1:0] cfg_data;
	logic                          push;
	logic                          full;
	cqh_pkg::cqh_pixel_t           pixel;
	logic                          empty;
	logic                          pop;
	cqh_pkg::cqh_result_t          result;

	histogram_scoreboard sb = new;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;

	color_quantize_histogram u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic cqh_pkg::cqh_pixel_t make_px(cqh_pkg::cqh_cmd_t cmd, logic [7:0] r,
			logic [7:0] g, logic [7:0] b, logic [cqh_pkg::CODE_W-1:0] sel, logic last);
		cqh_pkg::cqh_pixel_t px;
		px.cmd = cmd;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.bin_select = sel;
		px.last_pixel = last;
		return px;
	endfunction

	// Offers one request, idling first as the current phase asks.
	task send_pixel(cqh_pkg::cqh_pixel_t px);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < send_idle_pct) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				pixel <= px;
				break;
			end
		end
		do @(posedge clk); while (full);
		sb.note_request(px);
	endtask

	// Writes one configuration register.
	task write_reg(cqh_pkg::cqh_reg_t idx, logic [cqh_pkg::CFG_DAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every predicted result has come out, then lets the pipe settle.
	task wait_quiet();
		@(negedge clk);
		push <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sets both registers; upper data bits are random and must not matter.
	task set_mode(logic [2:0] qbits, logic gray);
		logic [cqh_pkg::CFG_DAT_W-1:0] d;
		wait_quiet();
		d = cqh_pkg::CFG_DAT_W'($urandom);
		d[2:0] = qbits;
		write_reg(cqh_pkg::REG_QUANT_BITS, d);
		d = cqh_pkg::CFG_DAT_W'($urandom);
		d[0] = gray;
		write_reg(cqh_pkg::REG_GRAY_MODE, d);
	endtask

	// One random request: mostly palette pixels that pile into a few bins,
	// with reads of recently hit bins, plus fully random pixels and reads.
	task automatic send_random(const ref logic [7:0] palette [6][3]);
		cqh_pkg::cqh_pixel_t px;
		int                  pick, k;
		px = make_px(cqh_pkg::CMD_ADD, 8'($urandom), 8'($urandom), 8'($urandom),
			cqh_pkg::CODE_W'($urandom), $urandom_range(0, 9) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			k = $urandom_range(0, 5);
			px.red = {palette[k][0][7:3], px.red[2:0]};
			px.green = {palette[k][1][7:3], px.green[2:0]};
			px.blue = {palette[k][2][7:3], px.blue[2:0]};
		end else if (pick < 92 && pick >= 80 && sb.recent_codes.size() != 0) begin
			px.cmd = cqh_pkg::CMD_READ;
			px.bin_select = sb.recent_codes[$urandom_range(0, sb.recent_codes.size() - 1)];
		end else if (pick >= 92) begin
			px.cmd = cqh_pkg::CMD_READ;
		end
		send_pixel(px);
	endtask

	// Receiver: pops with random stalls, or holds off while hold_left runs down.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Result monitor.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
				sb.check_result(result);
		end
	end

	// Watchdog on cycles with no handshake at all.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Main sequence.
	initial begin
		logic [2:0] phase_qbits [PHASE_COUNT];
		logic       phase_gray [PHASE_COUNT];
		int         phase_send [PHASE_COUNT];
		int         phase_recv [PHASE_COUNT];
		int         phase_items;
		logic [7:0] palette [6][3];

		phase_qbits = '{3'd1, 3'd5, 3'd3, 3'd0, 3'd2, 3'd7, 3'd4, 3'd6};
		phase_gray = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		phase_send = '{0, 84, 0, 38, 0, 84, 0, 38};
		phase_recv = '{0, 0, 84, 38, 0, 0, 84, 38};

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = cqh_pkg::REG_QUANT_BITS;
		cfg_data = '0;
		push = 1'b0;
		pixel = '0;
		pop = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Full resolution in color mode: sample extremes, repeats of one bin
		// back to back, read-and-clear, and fields the command ignores.
		set_mode(3'd5, 1'b0);
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'h00, 8'h00, 8'h00, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'hFF, 8'hFF, 8'hFF, '0, 1'b1));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'hFF, 8'h00, 8'h00, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'h00, 8'hFF, 8'h00, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'h00, 8'h00, 8'hFF, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'hFF, 8'hFF, 8'hFF, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'hF8, 8'hF8, 8'hF8, '1, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 15'h7FFF, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 15'h7FFF, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'hFF, 8'hFF, 8'hFF, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF, 15'h0000, 1'b1));

		// Zero quant bits acts as one, in gray mode; old counts survive.
		set_mode(3'd0, 1'b1);
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'h80, 8'h00, 8'h00, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'h7F, 8'hFF, 8'hFF, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'hC8, 8'h12, 8'h34, '0, 1'b1));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 15'd7, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 15'd0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 15'h7FFF, 1'b0));

		// Quant bits above the maximum act as the maximum.
		set_mode(3'd7, 1'b0);
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'hFF, 8'h80, 8'h01, '0, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_ADD, 8'h08, 8'h10, 8'h20, '0, 1'b1));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 15'h5555, 1'b0));
		send_pixel(make_px(cqh_pkg::CMD_READ, 8'h00, 8'h00, 8'h00, 15'h2AAA, 1'b0));

		// Random phases, each with its own registers, palette and idling.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_mode(phase_qbits[p], phase_gray[p]);
			send_idle_pct = phase_send[p];
			recv_stall_pct = phase_recv[p];
			for (int k = 0; k < 6; k++)
				for (int c = 0; c < 3; c++)
					palette[k][c] = 8'($urandom);
			phase_items = 70;
			// Long receiver hold-off while requests keep coming, so the block
			// fills up and pushes back on its input.
			if (p == 4) begin
				hold_left = 400;
				phase_items = 130;
			end
			for (int i = 0; i < phase_items; i++)
				send_random(palette);
		end

		wait_quiet();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/cqh_pkg.sv
src/cqh_fifo.sv
src/cqh_front.sv
src/cqh_back.sv
src/color_quantize_histogram.sv
tb/tb.sv
